// ----- rtl/cc_pkg.sv -----
// ----------------------------------------------------------------------------
// cc_pkg
// Shared types and constants for the clock-replacement set-associative cache.
// ----------------------------------------------------------------------------
package cc_pkg;

  localparam int ADDR_W  = 32;
  localparam int WAYS    = 8;
  localparam int WAY_W   = 3;
  localparam int WCNT_W  = 4;
  localparam int SET_W   = 8;
  localparam int SETS    = 256;
  localparam int POS_W   = 6;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_INDEX_CNT  = 2'd1;
  localparam logic [1:0] REG_INDEX_POS  = 2'd2;
  localparam logic [1:0] REG_WAY_COUNT  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SET_W-1:0]  set;
    logic [WCNT_W-1:0] ways;
  } cc_item_t;

  typedef struct packed {
    logic [WAYS-1:0]  vld;
    logic [WAYS-1:0]  refb;
    logic [WAY_W-1:0] hand;
  } cc_meta_t;

  typedef logic [WAYS-1:0][ADDR_W-1:0] cc_tag_row_t;

endpackage

// ----- rtl/cc_front.sv -----
// ----------------------------------------------------------------------------
// cc_front
// Config registers and address classification: masked tag, set index, ways.
// ----------------------------------------------------------------------------
module cc_front import cc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADDR_W-1:0]   line_address,
  output logic                push,
  output cc_item_t            push_item,
  input  logic                q_ready
);

  logic [5:0]  line_width;
  logic [3:0]  index_cnt;
  logic [47:0] index_pos;
  logic [3:0]  way_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 6'd32;
      index_cnt  <= 4'd0;
      index_pos  <= 48'd0;
      way_cnt    <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_LINE_WIDTH: line_width <= pwdata[5:0];
        REG_INDEX_CNT:  index_cnt  <= pwdata[3:0];
        REG_INDEX_POS:  index_pos  <= pwdata[47:0];
        REG_WAY_COUNT:  way_cnt    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_LINE_WIDTH: prdata = {58'd0, line_width};
      REG_INDEX_CNT:  prdata = {60'd0, index_cnt};
      REG_INDEX_POS:  prdata = {16'd0, index_pos};
      REG_WAY_COUNT:  prdata = {60'd0, way_cnt};
      default:        prdata = '0;
    endcase
  end

  logic [5:0]        w;
  logic [3:0]        nb;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] addr_m;
  logic [SET_W-1:0]  setv;
  logic [5:0]        pos;
  logic [5:0]        bit_sel;
  logic              sbit;

  always_comb begin
    w  = (line_width > 6'd32) ? 6'd32 : line_width;
    nb = (index_cnt > 4'd8) ? 4'd8 : index_cnt;
    for (int i = 0; i < ADDR_W; i++) begin
      mask[i] = (6'(i) < w);
    end
    addr_m = line_address & mask;
    setv    = '0;
    pos     = '0;
    bit_sel = '0;
    sbit    = 1'b0;
    for (int k = 0; k < 8; k++) begin
      pos     = index_pos[6*k +: 6];
      bit_sel = w - 6'd1 - pos;
      sbit    = (pos < w) ? addr_m[bit_sel[4:0]] : 1'b0;
      if (4'(k) < nb) begin
        setv = {setv[SET_W-2:0], sbit};
      end
    end
    push_item.addr = addr_m;
    push_item.set  = setv;
    if (way_cnt == 4'd0) begin
      push_item.ways = 4'd1;
    end else if (way_cnt > 4'd8) begin
      push_item.ways = 4'd8;
    end else begin
      push_item.ways = way_cnt;
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

endmodule

// ----- rtl/cc_queue.sv -----
// ----------------------------------------------------------------------------
// cc_queue
// Two-entry queue between the classifier and the lookup engine.
// ----------------------------------------------------------------------------
module cc_queue import cc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cc_item_t push_item,
  output logic     q_ready,
  output logic     q_valid,
  output cc_item_t q_item,
  input  logic     pop
);

  cc_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

endmodule

// ----- rtl/cc_back.sv -----
// ----------------------------------------------------------------------------
// cc_back
// Lookup engine: set read, way compare, clock victim choice, write back.
// ----------------------------------------------------------------------------
module cc_back import cc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cc_item_t           q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [WAY_W-1:0]   way,
  output logic [SET_W-1:0]   set_index,
  output logic [ADDR_W-1:0]  miss_total
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic        state;
  cc_item_t    cur;
  cc_tag_row_t tag_mem [SETS];
  cc_meta_t    meta_mem [SETS];
  logic [SETS-1:0] row_ok;
  cc_tag_row_t tag_rd;
  cc_meta_t    meta_rd;
  logic        ok_rd;
  logic [ADDR_W-1:0] miss_cnt;

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_item;
      tag_rd  <= tag_mem[q_item.set];
      meta_rd <= meta_mem[q_item.set];
    end
  end

  cc_meta_t         m;
  logic             hit_any;
  logic [WAY_W-1:0] hway;
  logic [WAY_W-1:0] h;
  logic [WAY_W-1:0] p;
  logic [WAY_W-1:0] vic;
  logic [WAY_W-1:0] vic_next;
  logic [WAYS-1:0]  refs_s;
  logic             found;
  logic             finish;
  cc_meta_t         meta_new;
  cc_tag_row_t      tag_new;
  logic [ADDR_W-1:0] miss_next;

  always_comb begin
    m = ok_rd ? meta_rd : '0;
    hit_any = 1'b0;
    hway    = '0;
    for (int a = 0; a < WAYS; a++) begin
      if (!hit_any && 4'(a) < cur.ways && m.vld[a] && tag_rd[a] == cur.addr) begin
        hit_any = 1'b1;
        hway    = WAY_W'(a);
      end
    end
    h      = ({1'b0, m.hand} >= cur.ways) ? '0 : m.hand;
    refs_s = m.refb;
    found  = 1'b0;
    p      = h;
    vic    = h;
    for (int t = 0; t < WAYS; t++) begin
      if (4'(t) < cur.ways && !found) begin
        if (!refs_s[p]) begin
          found = 1'b1;
          vic   = p;
        end else begin
          refs_s[p] = 1'b0;
          p = (({1'b0, p} + 4'd1) == cur.ways) ? '0 : p + 3'd1;
        end
      end
    end
    if (!found) vic = p;
    vic_next = (({1'b0, vic} + 4'd1) == cur.ways) ? '0 : vic + 3'd1;
    tag_new  = tag_rd;
    if (hit_any) begin
      meta_new      = m;
      meta_new.refb = m.refb | (WAYS'(1) << hway);
    end else begin
      meta_new.vld  = m.vld | (WAYS'(1) << vic);
      meta_new.refb = refs_s | (WAYS'(1) << vic);
      meta_new.hand = vic_next;
      tag_new[vic]  = cur.addr;
    end
    miss_next = (miss_cnt == '1) ? miss_cnt : miss_cnt + 32'd1;
  end

  assign finish = (state == S_LOOK) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (finish) begin
      tag_mem[cur.set]  <= tag_new;
      meta_mem[cur.set] <= meta_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_ok    <= '0;
      ok_rd     <= 1'b0;
      miss_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        ok_rd <= row_ok[q_item.set];
        state <= S_LOOK;
      end
      if (finish) begin
        row_ok[cur.set] <= 1'b1;
        if (!hit_any) miss_cnt <= miss_next;
        out_valid <= 1'b1;
        state     <= S_IDLE;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit        <= hit_any;
      way        <= hit_any ? hway : vic;
      set_index  <= cur.set;
      miss_total <= hit_any ? miss_cnt : miss_next;
    end
  end

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> miss_cnt >= $past(miss_cnt))
    else $error("miss count went down");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (finish && hit_any) |=> miss_cnt == $past(miss_cnt))
    else $error("hit changed miss count");

  a_way_in_range: assert property (@(posedge clk) disable iff (rst)
    finish |-> ({1'b0, (hit_any ? hway : vic)} < cur.ways))
    else $error("way outside ways in use");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_LOOK)
    else $error("pop did not start a lookup");

endmodule

// ----- rtl/clock_set_associative_cache.sv -----
// ----------------------------------------------------------------------------
// clock_set_associative_cache
// Set-associative cache tag model with clock (second chance) replacement.
//
// Input channel in_valid/in_ready carries one line address per beat. The
// output channel out_valid/out_ready returns one beat per input: hit flag,
// way hit or filled, set index and the saturating miss count.
// Config registers sit on the APB port at 0x00 line width, 0x08 index bit
// count, 0x10 index positions, 0x18 way count; write only while idle.
// A two-entry queue decouples classification from the lookup engine.
// Each lookup first does a registered set read as the beat is popped, then
// compare, victim choice and write back once the output can take the result.
// The engine pops only while idle: no new beat until the last one is done.
// Reset clears the per-set row flags, so all sets read empty at once; no
// clearing pass is needed. When out_ready is low the result is held, the
// engine stalls and the queue absorbs up to two further beats.
// ----------------------------------------------------------------------------
module clock_set_associative_cache import cc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADDR_W-1:0]   line_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [WAY_W-1:0]    way,
  output logic [SET_W-1:0]    set_index,
  output logic [ADDR_W-1:0]   miss_total
);

  logic     push;
  cc_item_t push_item;
  logic     q_ready;
  logic     q_valid;
  cc_item_t q_item;
  logic     pop;

  assign pready = 1'b1;

  cc_front u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid, .in_ready, .line_address, .push, .push_item, .q_ready
  );

  cc_queue u_queue (
    .clk, .rst, .push, .push_item, .q_ready, .q_valid, .q_item, .pop
  );

  cc_back u_back (
    .clk, .rst, .q_valid, .q_item, .pop, .out_valid, .out_ready,
    .hit, .way, .set_index, .miss_total
  );

endmodule
